/* src/cobsd_pkg.sv */
// Shared types, codes and helpers for the COBS stream decoder.
// No dependencies; imported by cobsd_out_if and every module of the block.
package cobsd_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_DROP   = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [15:0] REPORT_MAX = 16'hFFFF;

  // one queued request from the front to the back
  typedef struct packed {
    logic [1:0]              kind;
    logic [7:0]              data;
    logic [LENGTH_WIDTH-1:0] length;
  } result_t;

  // reported length is clamped to 16 bits whatever the counter width
  function automatic logic [15:0] clamp_len(input logic [LENGTH_WIDTH-1:0] n);
    logic [LENGTH_WIDTH+15:0] wide;
    wide = {16'b0, n};
    if (wide > (LENGTH_WIDTH + 16)'(REPORT_MAX)) begin
      return REPORT_MAX;
    end
    return wide[15:0];
  endfunction

endpackage

/* src/cobsd_if.sv */
// Valid/ready channel interfaces for the COBS stream decoder.
// Depends on cobsd_pkg.
interface cobsd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface cobsd_out_if;
  import cobsd_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output out_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_length,
                  output ready);
endinterface

/* src/cobsd_front.sv */
// Front end: accepts stream bytes, runs the COBS frame state and
// classifies each byte into at most one result request. Depends on cobsd_pkg.
module cobsd_front (
  input  logic                clk,
  input  logic                rst,
  cobsd_in_if.sink            in_stream,
  input  logic                q_full,
  output logic                q_push,
  output cobsd_pkg::result_t  q_data
);
  import cobsd_pkg::*;

  logic [1:0]              mode, mode_next;
  logic [7:0]              run, run_next;
  logic                    owed, owed_next;
  logic [LENGTH_WIDTH-1:0] count, count_next, count_inc;
  logic                    accept;
  logic [7:0]              b;

  assign in_stream.ready = !q_full;
  assign accept          = in_stream.valid && in_stream.ready;
  assign b               = in_stream.in_byte;
  assign count_inc       = (count == '1) ? count : count + 1'b1;

  always_comb begin
    mode_next  = mode;
    run_next   = run;
    owed_next  = owed;
    count_next = count;
    q_push     = 1'b0;
    q_data     = '{kind: KIND_DATA, data: 8'd0, length: '0};
    if (accept) begin
      if (in_stream.func) begin
        mode_next  = MODE_DROP;
        run_next   = 8'd0;
        owed_next  = 1'b0;
        count_next = '0;
      end else begin
        unique case (mode)
          MODE_DROP: begin
            if (b == 8'd0) mode_next = MODE_WAIT;
          end
          MODE_DECODE: begin
            if (run != 8'd0) begin
              q_push = 1'b1;
              if (b == 8'd0) begin
                // zero inside a run: malformed
                mode_next  = MODE_WAIT;
                run_next   = 8'd0;
                owed_next  = 1'b0;
                count_next = '0;
                q_data.kind = KIND_BAD;
              end else begin
                run_next    = run - 8'd1;
                count_next  = count_inc;
                q_data.data = b;
              end
            end else if (b == 8'd0) begin
              q_push        = 1'b1;
              q_data.kind   = KIND_DONE;
              q_data.length = count;
              mode_next     = MODE_WAIT;
              run_next      = 8'd0;
              owed_next     = 1'b0;
              count_next    = '0;
            end else begin
              run_next  = b - 8'd1;
              owed_next = (b != 8'hFF);
              if (owed) begin
                // the implied zero of the previous code byte
                q_push     = 1'b1;
                count_next = count_inc;
              end
            end
          end
          default: begin
            // waiting; unused mode code behaves the same
            mode_next = MODE_WAIT;
            if (b != 8'd0) begin
              mode_next = MODE_DECODE;
              run_next  = b - 8'd1;
              owed_next = (b != 8'hFF);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_WAIT;
      run   <= 8'd0;
      owed  <= 1'b0;
      count <= '0;
    end else begin
      mode  <= mode_next;
      run   <= run_next;
      owed  <= owed_next;
      count <= count_next;
    end
  end

endmodule

/* src/cobsd_queue.sv */
// Short request queue between the front and back ends.
// Depends on cobsd_pkg.
module cobsd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cobsd_pkg::result_t  push_data,
  input  logic                pop,
  output cobsd_pkg::result_t  head,
  output logic                full,
  output logic                nonempty
);
  import cobsd_pkg::*;

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] used;

  assign full     = (used == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (used != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      used <= used + 1'b1;
      else if (pop && !push) used <= used - 1'b1;
    end
  end

endmodule

/* src/cobsd_back.sv */
// Back end: takes queued requests and presents them in the output
// register, clamping the frame length. Depends on cobsd_pkg.
module cobsd_back (
  input  logic                clk,
  input  logic                rst,
  input  cobsd_pkg::result_t  head,
  input  logic                nonempty,
  output logic                pop,
  cobsd_out_if.source         out_stream
);
  import cobsd_pkg::*;

  logic valid;

  assign pop              = nonempty && (!valid || out_stream.ready);
  assign out_stream.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || out_stream.ready) begin
      valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_stream.kind         <= head.kind;
      out_stream.out_byte     <= head.data;
      out_stream.frame_length <= (head.kind == KIND_DONE) ? clamp_len(head.length) : 16'd0;
    end
  end

endmodule

/* src/cobs_stream_decoder.sv */
// Top level of the COBS stream decoder: front end, request queue, back end.
// Depends on cobsd_pkg, cobsd_if, cobsd_front, cobsd_queue, cobsd_back.
//
// in_stream carries one encoded byte (func = 0) or a discard command
// (func = 1) per accepted request; zero bytes delimit frames. out_stream
// returns decoded data bytes, frame-complete reports with the decoded
// length (clamped to 16 bits) and malformed-frame reports.
// One input byte is taken per cycle while the two-entry queue has room;
// each gives zero or one result. A result is written into the queue by
// the edge that takes its byte and is loaded into the output register
// once it is at the queue head and that register is free. With the
// receiver ready the block sustains one byte per cycle.
// Reset (rst, synchronous) puts the decoder in the wait-for-frame mode
// with an empty queue and no output pending. When the receiver stalls the
// output register holds, the queue fills, and in_stream.ready drops once
// it is full; nothing is lost or repeated.
module cobs_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  cobsd_in_if.sink    in_stream,
  cobsd_out_if.source out_stream
);
  import cobsd_pkg::*;

  result_t q_data, q_head;
  logic    q_push, q_pop, q_full, q_nonempty;

  cobsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  cobsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  cobsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .nonempty   (q_nonempty),
    .pop        (q_pop),
    .out_stream (out_stream)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_stream.valid)
    else $error("popped request not presented");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("pop from an empty queue");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid |-> (out_stream.kind == KIND_DATA || out_stream.kind == KIND_DONE ||
                          out_stream.kind == KIND_BAD))
    else $error("illegal result kind");

endmodule

/* tb/sv/cobs_stream_decoder_test.sv */
// Self-checking bench for cobs_stream_decoder: a directed table, then random
// COBS frames with noise. Random stalls on both sides.
// Depends on cobsd_pkg, cobsd_if and the cobs_stream_decoder RTL.
module cobs_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cobsd_pkg::*;

  localparam int IDLE_PCT      = 36;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] len;
  } decoded_t;

  typedef struct packed {
    bit          func;
    logic [7:0]  b;
    bit          typed;     // expectation written in the row, not predicted
    bit          has_res;
    decoded_t    res;
  } row_t;

  localparam decoded_t NO_RES = '{KIND_DATA, 8'h00, 16'h0000};

  localparam row_t DIRECTED_ROWS[24] = '{
    '{1'b0, 8'h00, 1'b1, 1'b0, NO_RES},                          // empty frame while waiting
    '{1'b0, 8'h01, 1'b1, 1'b0, NO_RES},                          // frame start
    '{1'b0, 8'h00, 1'b1, 1'b1, '{KIND_DONE, 8'h00, 16'h0000}},   // owed zero dropped, length 0
    '{1'b0, 8'hFF, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'hFF, 1'b1, 1'b1, '{KIND_DATA, 8'hFF, 16'h0000}},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{KIND_BAD, 8'h00, 16'h0000}},    // zero inside a run
    '{1'b0, 8'h03, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h80, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h7F, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h02, 1'b0, 1'b0, NO_RES},                          // code pays the owed zero
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h02, 1'b0, 1'b0, NO_RES},
    '{1'b1, 8'hAA, 1'b1, 1'b0, NO_RES},                          // discard mid-frame
    '{1'b0, 8'h05, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'h00, 1'b1, 1'b0, NO_RES},                          // delimiter leaves drop
    '{1'b0, 8'h04, 1'b1, 1'b0, NO_RES},
    '{1'b1, 8'h00, 1'b1, 1'b0, NO_RES},                          // discard ignores its byte
    '{1'b0, 8'h00, 1'b1, 1'b0, NO_RES},
    '{1'b0, 8'hFE, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_RES},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{KIND_BAD, 8'h00, 16'h0000}},
    '{1'b0, 8'h00, 1'b1, 1'b0, NO_RES}
  };

  logic clk;
  logic rst;

  cobsd_in_if  in_stream();
  cobsd_out_if out_stream();

  cobs_stream_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  // decoder state mirror
  logic [1:0]              dec_mode;
  logic [7:0]              run_left;
  bit                      zero_due;
  logic [LENGTH_WIDTH-1:0] byte_count;

  decoded_t expected_results[$];
  int       mismatches;
  int       items_sent;
  bit       steady;

  function automatic void bump_count();
    if (byte_count != '1) begin
      byte_count = byte_count + 1'b1;
    end
  endfunction

  function automatic void open_run(input logic [7:0] code);
    run_left = code - 8'd1;
    zero_due = (code != 8'hFF);
  endfunction

  // returns 1 when the request yields a result, placed in r
  function automatic bit decode_step(input bit f, input logic [7:0] b, output decoded_t r);
    logic [LENGTH_WIDTH+15:0] wide;
    r = NO_RES;
    if (f) begin
      run_left = '0;
      zero_due = 0;
      byte_count = '0;
      dec_mode = MODE_DROP;
      return 0;
    end
    if (dec_mode == MODE_DROP) begin
      if (b == 8'h00) begin
        dec_mode = MODE_WAIT;
      end
      return 0;
    end
    if (dec_mode != MODE_DECODE) begin
      dec_mode = MODE_WAIT;
      if (b != 8'h00) begin
        open_run(b);
        dec_mode = MODE_DECODE;
      end
      return 0;
    end
    if (run_left != 8'h00) begin
      if (b == 8'h00) begin
        run_left = '0;
        zero_due = 0;
        byte_count = '0;
        dec_mode = MODE_WAIT;
        r.kind = KIND_BAD;
        return 1;
      end
      run_left = run_left - 8'd1;
      bump_count();
      r.kind = KIND_DATA;
      r.data = b;
      return 1;
    end
    if (b == 8'h00) begin
      wide = {16'b0, byte_count};
      r.kind = KIND_DONE;
      r.len = (wide > (LENGTH_WIDTH + 16)'(REPORT_MAX)) ? REPORT_MAX : wide[15:0];
      run_left = '0;
      zero_due = 0;
      byte_count = '0;
      dec_mode = MODE_WAIT;
      return 1;
    end
    if (zero_due) begin
      open_run(b);
      bump_count();
      r.kind = KIND_DATA;
      return 1;
    end
    open_run(b);
    return 0;
  endfunction

  task automatic send_request(input bit f, input logic [7:0] b, input bit typed = 0,
                              input bit typed_has = 0, input decoded_t typed_res = NO_RES);
    decoded_t r;
    bit       has;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_stream.valid <= 1'b0;
      @(posedge clk);
    end
    in_stream.valid   <= 1'b1;
    in_stream.func    <= f;
    in_stream.in_byte <= b;
    @(posedge clk);
    while (!in_stream.ready) @(posedge clk);
    has = decode_step(f, b, r);
    if (typed) begin
      has = typed_has;
      r = typed_res;
    end
    if (has) begin
      expected_results.push_back(r);
    end
    items_sent++;
  endtask

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(1, 6));
    if (r < 85) return 8'($urandom_range(1, 20));
    if (r < 90) return 8'hFF;
    if (r < 93) return 8'hFE;
    return 8'($urandom_range(1, 255));
  endfunction

  // mostly well-formed frames; some broken by a stray zero, a discard, or plain noise
  task automatic random_frame();
    int         pick;
    int         runs;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    runs = $urandom_range(1, 4);
    if (pick >= 95) begin
      repeat ($urandom_range(1, 6)) begin
        send_request($urandom_range(0, 5) == 0,
                     ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
      return;
    end
    for (int i = 0; i < runs; i++) begin
      code = pick_code();
      send_request(1'b0, code);
      for (int k = 1; k < int'(code); k++) begin
        if (pick >= 80 && pick < 88 && $urandom_range(0, 15) == 0) begin
          send_request(1'b0, 8'h00);
          return;
        end
        if (pick >= 88 && $urandom_range(0, 15) == 0) begin
          send_request(1'b1, 8'($urandom));
          repeat ($urandom_range(0, 4)) send_request(1'b0, 8'($urandom_range(1, 255)));
          send_request(1'b0, 8'h00);
          return;
        end
        send_request(1'b0, 8'($urandom_range(1, 255)));
      end
    end
    send_request(1'b0, 8'h00);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random back-pressure and in-order compare
  initial begin
    decoded_t want;
    out_stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_stream.valid && out_stream.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got kind %0d byte %02h length %0d", $time,
                   out_stream.kind, out_stream.out_byte, out_stream.frame_length);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_stream.kind !== want.kind || out_stream.out_byte !== want.data ||
              out_stream.frame_length !== want.len) begin
            $display(
              "%0t: expected kind %0d byte %02h len %0d, got kind %0d byte %02h len %0d",
              $time, want.kind, want.data, want.len,
              out_stream.kind, out_stream.out_byte, out_stream.frame_length);
            mismatches++;
          end
        end
      end
      out_stream.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: too long with no request moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_stream.valid && in_stream.ready) ||
          (out_stream.valid && out_stream.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    items_sent = 0;
    steady = 0;
    dec_mode = MODE_WAIT;
    run_left = '0;
    zero_due = 0;
    byte_count = '0;
    rst <= 1'b1;
    in_stream.valid   <= 1'b0;
    in_stream.func    <= 1'b0;
    in_stream.in_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].has_res, DIRECTED_ROWS[i].res);
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (items_sent >= 500 && items_sent < 800);
      random_frame();
    end
    steady = 0;
    in_stream.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
